// ===== sv/lpseg_pkg.sv =====
package lpseg_pkg;

  localparam int MAX_BLOCK    = 4096;
  localparam int MAX_SEGMENTS = 63;

  localparam logic [1:0] OP_SEEK = 2'd0;
  localparam logic [1:0] OP_LOOP = 2'd1;
  localparam logic [1:0] OP_PLAY = 2'd2;
  localparam logic [1:0] OP_FEED = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;

  localparam logic [1:0] REG_TIMELINE_END    = 2'd0;
  localparam logic [1:0] REG_TIMELINE_LOADED = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE      = 2'd2;

  localparam logic [12:0] BLOCK_SIZE_RESET = 13'd256;

  // One decoded request as it travels from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] target_frame;
    logic [31:0] loop_stop;
    logic        loop_on;
    logic        play_on;
    logic [12:0] frames;
  } cmd_t;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [12:0] seg_len;
    logic        wrapped;
    logic [2:0]  status;
    logic        now_playing;
    logic [31:0] position;
    logic [12:0] frames_out;
    logic        last;
  } res_t;

endpackage

// ===== sv/lpseg_front.sv =====
module lpseg_front
  import lpseg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] target_frame,
  input  logic [31:0] loop_stop,
  input  logic        loop_on,
  input  logic        play_on,
  input  logic [15:0] ring_space,
  input  logic [12:0] block_size,
  output logic        cmd_valid,
  input  logic        cmd_pop,
  output cmd_t        cmd_data
);

  cmd_t        queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [12:0] bs_clamped;
  logic [12:0] frames;
  cmd_t        cmd_in;
  logic        push;

  // A block size of zero acts as one frame; the ring space caps the feed.
  always_comb begin
    if (block_size == 13'd0) begin
      bs_clamped = 13'd1;
    end else if (block_size > 13'(MAX_BLOCK)) begin
      bs_clamped = 13'(MAX_BLOCK);
    end else begin
      bs_clamped = block_size;
    end
    if (ring_space < {3'b000, bs_clamped}) begin
      frames = ring_space[12:0];
    end else begin
      frames = bs_clamped;
    end
  end

  assign cmd_in = '{op: op, target_frame: target_frame, loop_stop: loop_stop,
                    loop_on: loop_on, play_on: play_on, frames: frames};

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== sv/lpseg_back.sv =====
module lpseg_back
  import lpseg_pkg::*;
#(
  parameter int SegLimit = MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd_data,
  input  logic [31:0] timeline_end,
  input  logic        timeline_loaded,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res_data
);

  localparam int SW = $clog2(SegLimit + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  logic [1:0]    state;
  logic [31:0]   playhead;
  logic          is_playing;
  logic          loop_enabled;
  logic [31:0]   loop_begin;
  logic [31:0]   loop_finish;
  logic [12:0]   frames;
  logic [31:0]   walk;
  logic [12:0]   mixed;
  logic [SW-1:0] nseg;
  logic [SW-1:0] ntot;
  logic [2:0]    status;
  logic [12:0]   frames_out;

  logic          out_free;
  logic          res_load;
  logic [31:0]   wph;
  logic          wrap;
  logic [31:0]   rem;
  logic [12:0]   left;
  logic [12:0]   chunk;
  logic          all_mixed;
  logic          seg_cap;
  logic          rem_zero;
  logic          ended;

  assign out_free = !res_valid || res_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_load = out_free && (((state == S_EMIT) && (nseg != ntot)) ||
                                 (state == S_STATUS));

  // Segment cutter: one segment per cycle from the walking playhead (in the emit pass only while the output is free).
  always_comb begin
    wrap = loop_enabled && (walk >= loop_finish);
    wph  = wrap ? loop_begin : walk;
    rem  = loop_enabled ? (loop_finish - wph) : (timeline_end - wph);
    left = frames - mixed;
    if (rem < {19'd0, left}) begin
      chunk = rem[12:0];
    end else begin
      chunk = left;
    end
    all_mixed = (mixed == frames);
    seg_cap   = (nseg == SW'(SegLimit));
    rem_zero  = loop_enabled && (rem == 32'd0);
    ended     = !loop_enabled && (wph >= timeline_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      playhead     <= 32'd0;
      is_playing   <= 1'b0;
      loop_enabled <= 1'b0;
      loop_begin   <= 32'd0;
      loop_finish  <= 32'd0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            frames_out <= 13'd0;
            case (cmd_data.op)
              OP_SEEK: begin
                playhead <= cmd_data.target_frame;
                status   <= ST_OK;
                state    <= S_STATUS;
              end
              OP_LOOP: begin
                state <= S_STATUS;
                if (cmd_data.loop_on && (cmd_data.loop_stop <= cmd_data.target_frame)) begin
                  status <= ST_REJECT;
                end else begin
                  status       <= ST_OK;
                  loop_enabled <= cmd_data.loop_on;
                  loop_begin   <= cmd_data.target_frame;
                  loop_finish  <= cmd_data.loop_stop;
                  if (cmd_data.loop_on && (playhead >= cmd_data.loop_stop)) begin
                    playhead <= cmd_data.target_frame;
                  end
                end
              end
              OP_PLAY: begin
                is_playing <= cmd_data.play_on;
                status     <= ST_OK;
                state      <= S_STATUS;
              end
              default: begin
                if (!is_playing || !timeline_loaded) begin
                  status <= ST_IDLE;
                  state  <= S_STATUS;
                end else if (cmd_data.frames == 13'd0) begin
                  status <= ST_FULL;
                  state  <= S_STATUS;
                end else begin
                  status <= ST_OK;
                  frames <= cmd_data.frames;
                  walk   <= playhead;
                  mixed  <= 13'd0;
                  nseg   <= '0;
                  state  <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // First pass: find where the feed stops and commit the final state,
          // so every segment of the second pass can carry it.
          if (all_mixed || seg_cap || rem_zero || ended) begin
            if (all_mixed) begin
              frames_out <= frames;
              playhead   <= walk;
            end else if (seg_cap) begin
              status     <= ST_TRUNC;
              frames_out <= mixed;
              playhead   <= walk;
            end else if (rem_zero) begin
              status     <= ST_TRUNC;
              frames_out <= mixed;
              playhead   <= wph;
            end else begin
              is_playing <= 1'b0;
              frames_out <= frames;
              playhead   <= wph;
            end
            ntot  <= nseg;
            walk  <= playhead;
            mixed <= 13'd0;
            nseg  <= '0;
            state <= S_EMIT;
          end else begin
            walk  <= wph + {19'd0, chunk};
            mixed <= mixed + chunk;
            nseg  <= nseg + 1'b1;
          end
        end
        S_EMIT: begin
          if (nseg == ntot) begin
            state <= S_STATUS;
          end else if (out_free) begin
            res_data  <= '{seg_start: wph, seg_len: chunk, wrapped: wrap,
                           status: ST_OK, now_playing: is_playing,
                           position: playhead, frames_out: 13'd0, last: 1'b0};
            walk  <= wph + {19'd0, chunk};
            mixed <= mixed + chunk;
            nseg  <= nseg + 1'b1;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            res_data  <= '{seg_start: 32'd0, seg_len: 13'd0, wrapped: 1'b0,
                           status: status, now_playing: is_playing,
                           position: playhead, frames_out: frames_out, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/loop_playhead_segmenter_unit.sv =====
// Playback transport: seek, set-loop, set-playing and feed requests enter a
// two-deep queue and are executed in order. Every request ends with one
// status result marked last; a feed first emits its mix segments. In a
// feed, one segment cutter walks the block twice, once to find the final
// playhead and play flag and once to emit the segments, one segment per
// cycle when the output is taken. Configuration (timeline end at 0x0,
// timeline loaded at 0x4, block size at 0x8) must be written only while
// no request is in flight.
module loop_playhead_segmenter_unit
  import lpseg_pkg::*;
#(
  parameter int SegLimit = MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] target_frame,
  input  logic [31:0] loop_stop,
  input  logic        loop_on,
  input  logic        play_on,
  input  logic [15:0] ring_space,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] seg_start,
  output logic [12:0] seg_len,
  output logic        wrapped,
  output logic [2:0]  status,
  output logic        now_playing,
  output logic [31:0] position,
  output logic [12:0] frames_out,
  output logic        last
);

  logic [31:0] timeline_end;
  logic        timeline_loaded;
  logic [12:0] block_size;
  logic        cfg_write;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd_data;
  res_t        res_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeline_end    <= 32'd0;
      timeline_loaded <= 1'b0;
      block_size      <= BLOCK_SIZE_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_TIMELINE_END:    timeline_end    <= pwdata;
        REG_TIMELINE_LOADED: timeline_loaded <= pwdata[0];
        REG_BLOCK_SIZE:      block_size      <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMELINE_END:    prdata = timeline_end;
      REG_TIMELINE_LOADED: prdata = {31'd0, timeline_loaded};
      REG_BLOCK_SIZE:      prdata = {19'd0, block_size};
      default:             prdata = 32'd0;
    endcase
  end

  lpseg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .target_frame (target_frame),
    .loop_stop    (loop_stop),
    .loop_on      (loop_on),
    .play_on      (play_on),
    .ring_space   (ring_space),
    .block_size   (block_size),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd_data     (cmd_data)
  );

  lpseg_back #(
    .SegLimit (SegLimit)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd_data        (cmd_data),
    .timeline_end    (timeline_end),
    .timeline_loaded (timeline_loaded),
    .res_valid       (out_valid),
    .res_ready       (out_ready),
    .res_data        (res_data)
  );

  assign seg_start   = res_data.seg_start;
  assign seg_len     = res_data.seg_len;
  assign wrapped     = res_data.wrapped;
  assign status      = res_data.status;
  assign now_playing = res_data.now_playing;
  assign position    = res_data.position;
  assign frames_out  = res_data.frames_out;
  assign last        = res_data.last;

endmodule
